### hw/rtl/adtu_pkg.sv
// Package: shared types, character codes and helpers for the ASCII decimal parser.
package adtu_pkg;

	// Character codes that steer the parser.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Widths of the value and of the narrow limit.
	localparam int unsigned NUM_W    = 64;
	localparam int unsigned NARROW_W = 32;

	// One byte handed to the accumulator.
	typedef struct packed {
		logic       fire;
		logic [7:0] ch;
	} step_t;

	// One parsed field.
	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic             bad_field;
	} result_t;

	// True for the bytes that close a field.
	function automatic logic is_term(input logic [7:0] ch);
		return (ch == CH_NUL) || (ch == CH_LF) || (ch == CH_CR);
	endfunction

endpackage

### hw/rtl/adtu_char_if.sv
// Interface: byte channel carrying one ASCII character per word.
interface adtu_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

### hw/rtl/adtu_res_if.sv
// Interface: result channel carrying one parsed field per word.
interface adtu_res_if;
	logic                          valid;
	logic                          ready;
	logic [adtu_pkg::NUM_W-1:0]    number;
	logic                          bad_field;

	modport source (output valid, output number, output bad_field, input ready);
	modport sink   (input valid, input number, input bad_field, output ready);
endinterface

### hw/rtl/adtu_cfg_if.sv
// Interface: configuration write channel for the narrow result register.
interface adtu_cfg_if;
	logic valid;
	logic ready;
	logic narrow_result;

	modport source (output valid, output narrow_result, input ready);
	modport sink   (input valid, input narrow_result, output ready);
endinterface

### hw/rtl/adtu_accum.sv
// Field accumulator: per-field state, multiply-by-ten update and result formation.
module adtu_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  adtu_pkg::step_t   step,
	input  logic              narrow,
	output adtu_pkg::result_t result
);

	logic [adtu_pkg::NUM_W-1:0] acc_q;
	logic                       seen_q;
	logic                       trail_q;
	logic                       err_q;

	logic                       term;
	logic                       space;
	logic                       digit;
	logic [3:0]                 dval;
	logic [adtu_pkg::NUM_W+3:0] acc_ext;
	logic [adtu_pkg::NUM_W+3:0] prod;
	logic                       ovf;
	logic                       bad;

	// Classify the byte.
	always_comb begin
		term  = adtu_pkg::is_term(step.ch);
		space = (step.ch == adtu_pkg::CH_SPACE);
		digit = (step.ch inside {[adtu_pkg::CH_ZERO:adtu_pkg::CH_NINE]});
		dval  = 4'(step.ch - adtu_pkg::CH_ZERO);
	end

	// Times ten plus digit as shift-add, with four guard bits for true overflow.
	always_comb begin
		acc_ext = {4'b0000, acc_q};
		prod    = (acc_ext << 3) + (acc_ext << 1) + {{(adtu_pkg::NUM_W){1'b0}}, dval};
		ovf     = |prod[adtu_pkg::NUM_W+3:adtu_pkg::NUM_W];
	end

	// Result of the field as it stands; only used when a terminator arrives.
	always_comb begin
		bad = err_q || !seen_q ||
			(narrow && (|acc_q[adtu_pkg::NUM_W-1:adtu_pkg::NARROW_W]));
		result.bad_field = bad;
		result.number    = bad ? '1 : acc_q;
	end

	// Field state update, one byte per cycle while step.fire is set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			seen_q  <= 1'b0;
			trail_q <= 1'b0;
			err_q   <= 1'b0;
		end else if (step.fire) begin
			if (term) begin
				acc_q   <= '0;
				seen_q  <= 1'b0;
				trail_q <= 1'b0;
				err_q   <= 1'b0;
			end else if (!err_q) begin
				if (space) begin
					if (seen_q) begin
						trail_q <= 1'b1;
					end
				end else if (trail_q) begin
					err_q <= 1'b1;
				end else begin
					seen_q <= 1'b1;
					if (!digit || ovf) begin
						err_q <= 1'b1;
					end else begin
						acc_q <= prod[adtu_pkg::NUM_W-1:0];
					end
				end
			end
		end
	end

endmodule

### hw/rtl/ascii_decimal_to_uint_parser.sv
// Top level: ASCII decimal field parser with byte input, result output and config port.
// The parser takes one ASCII byte per cycle unless stalled and emits one result word for each
// field, when a NUL, LF or CR byte closes it; all other bytes produce nothing. Throughput is
// one byte per clock unless stalled, set by the combinational accumulator loop (multiply by
// ten as shift-add plus the overflow check). A byte is registered on entry and acted on from
// that input register; a result is loaded into the output register when its terminator
// advances out of it. Input bytes keep flowing while a result waits; only a terminator in the
// input register that finds the output register still occupied, and not taken in that cycle,
// stalls the input. narrow_result may only be changed while the block is idle.
module ascii_decimal_to_uint_parser (
	input  logic   clk,
	input  logic   arst_n,
	adtu_char_if.sink   char_stream,
	adtu_res_if.source  result_stream,
	adtu_cfg_if.sink    cfg
);

	logic              valid_s1;
	logic [7:0]        ch_s1;
	logic              term_s1;
	logic              advance;
	logic              narrow_q;
	logic              out_valid_q;
	adtu_pkg::result_t out_q;
	adtu_pkg::result_t field_res;
	adtu_pkg::step_t   step;

	// Stage one moves on unless it holds a terminator and the output is still full.
	always_comb begin
		term_s1           = adtu_pkg::is_term(ch_s1);
		advance           = valid_s1 && (!term_s1 || !out_valid_q || result_stream.ready);
		char_stream.ready = !valid_s1 || advance;
		step.fire         = advance;
		step.ch           = ch_s1;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_stream.ready) begin
			valid_s1 <= char_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_stream.ready && char_stream.valid) begin
			ch_s1 <= char_stream.char_in;
		end
	end

	// Configuration register, always ready.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			narrow_q <= 1'b0;
		end else if (cfg.valid) begin
			narrow_q <= cfg.narrow_result;
		end
	end

	// Field accumulator.
	adtu_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.narrow (narrow_q),
		.result (field_res)
	);

	// Output register: loaded by a terminator, freed when the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && term_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && term_s1) begin
			out_q <= field_res;
		end
	end

	assign result_stream.valid     = out_valid_q;
	assign result_stream.number    = out_q.number;
	assign result_stream.bad_field = out_q.bad_field;

`ifndef SYNTHESIS
	// A terminator that leaves stage one always lands in the output register.
	a_term_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && term_s1) |=> out_valid_q)
		else $error("terminator advanced but no result was registered");

	// A bad field always reports an all-ones number.
	a_bad_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.bad_field) |-> (&out_q.number))
		else $error("bad field without all-ones number");

	// A waiting result is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_stream.ready) |-> !(advance && term_s1))
		else $error("pending result overwritten");
`endif

endmodule
